>>> hw/rtl/assert_macros.svh
// assertion macros included by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication from antecedent to consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

>>> hw/rtl/lpfm_pkg.sv
// shared types and constants of the frame manager
`default_nettype none
package lpfm_pkg;
  localparam int unsigned NumFramesDefault = 16;

  typedef enum logic [1:0] {
    ActPin     = 2'd0,
    ActUnpin   = 2'd1,
    ActDirty   = 2'd2,
    ActRelease = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StAllPinned   = 2'd1,
    StNotResident = 2'd2
  } status_e;
endpackage
`default_nettype wire

>>> hw/rtl/lru_pinned_frame_manager.sv
// lru buffer-pool frame manager with pinning
// usage:
//   one request enters on valid_i/action_i/table_id_i/page_number_i when stall_o is low.
//   the block then scans its frames one per cycle with a single shared
//   compare unit: a lookup pass, for a pin miss with an empty free list a
//   victim pass, then a recency update pass when the lru order changes.
//   one request is worked on at a time.
//   the result sits in an output register with valid_o until stall_i is low;
//   a new request is taken once the result has left.
//   after reset all frames are empty, the free list holds frames 0 upward
//   and no result is pending.
`default_nettype none
module lru_pinned_frame_manager
  import lpfm_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NumFramesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] table_id_i,
  input  wire logic [31:0] page_number_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [1:0]       status_o,
  output logic [3:0]       frame_o,
  output logic             hit_o,
  output logic             evict_valid_o,
  output logic             writeback_o,
  output logic [15:0]      evict_table_o,
  output logic [31:0]      evict_page_o
);
  localparam int unsigned IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_FRAMES - 1);

  typedef enum logic [2:0] {
    SIdle, SFind, SVictim, SApply, SAge, SOut
  } state_e;

  state_e                   state_q;
  logic [IW-1:0]            idx_q;
  logic [1:0]               act_q;
  logic [15:0]              tbl_q;
  logic [31:0]              pg_q;
  logic                     found_q;
  logic [IW-1:0]            fidx_q;
  logic                     vic_q;
  logic [IW-1:0]            vidx_q;
  logic [IW-1:0]            vrank_q;
  logic [IW-1:0]            old_q;
  logic                     ins_q;
  logic [NUM_FRAMES-1:0]    valid_q, pinned_q, dirty_q;
  logic [IW-1:0]            rank_q [NUM_FRAMES];
  logic [15:0]              ftbl_q [NUM_FRAMES];
  logic [31:0]              fpg_q  [NUM_FRAMES];
  logic [IW-1:0]            head_q;
  logic [CW-1:0]            count_q;

  logic [1:0]  status_q;
  logic [3:0]  frame_q;
  logic        hit_q, ev_q, wb_q;
  logic [15:0] evt_q;
  logic [31:0] evp_q;

  logic [IW-1:0] head_nx;
  assign head_nx = (head_q == LastIdx) ? '0 : head_q + 1'b1;

  assign stall_o = (state_q != SIdle);
  assign valid_o = (state_q == SOut);
  assign status_o = status_q;
  assign frame_o = frame_q;
  assign hit_o = hit_q;
  assign evict_valid_o = ev_q;
  assign writeback_o = wb_q;
  assign evict_table_o = evt_q;
  assign evict_page_o = evp_q;

  logic [IW-1:0] tgt;
  always_comb begin
    tgt = found_q ? fidx_q : vidx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q <= '0;
      found_q <= 1'b0;
      vic_q <= 1'b0;
      ins_q <= 1'b0;
      valid_q <= '0;
      pinned_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) rank_q[i] <= '0;
      head_q <= '0;
      count_q <= CW'(NUM_FRAMES);
    end else begin
      unique case (state_q)
        SIdle: begin
          if (valid_i) begin
            act_q <= action_i;
            tbl_q <= table_id_i;
            pg_q <= page_number_i;
            idx_q <= '0;
            found_q <= 1'b0;
            vic_q <= 1'b0;
            ins_q <= 1'b0;
            state_q <= SFind;
          end
        end
        SFind: begin
          if (!found_q && valid_q[idx_q] && ftbl_q[idx_q] == tbl_q
              && fpg_q[idx_q] == pg_q) begin
            found_q <= 1'b1;
            fidx_q <= idx_q;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            idx_q <= '0;
            state_q <= SApply;
            if (!(found_q || (valid_q[idx_q] && ftbl_q[idx_q] == tbl_q
                && fpg_q[idx_q] == pg_q)) && act_q == ActPin && count_q == '0)
              state_q <= SVictim;
          end
        end
        SVictim: begin
          if (valid_q[idx_q] && !pinned_q[idx_q]
              && (!vic_q || rank_q[idx_q] > vrank_q)) begin
            vic_q <= 1'b1;
            vidx_q <= idx_q;
            vrank_q <= rank_q[idx_q];
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            idx_q <= '0;
            state_q <= SApply;
          end
        end
        SApply: begin
          status_q <= StOk;
          frame_q <= '0;
          hit_q <= 1'b0;
          ev_q <= 1'b0;
          wb_q <= 1'b0;
          evt_q <= '0;
          evp_q <= '0;
          state_q <= SOut;
          if (act_q == ActPin) begin
            if (found_q) begin
              hit_q <= 1'b1;
              pinned_q[fidx_q] <= 1'b1;
              frame_q <= 4'(fidx_q);
              old_q <= rank_q[fidx_q];
              state_q <= SAge;
            end else if (count_q != '0) begin
              fidx_q <= head_q;
              found_q <= 1'b1;
              ins_q <= 1'b1;
              head_q <= head_nx;
              count_q <= count_q - 1'b1;
              valid_q[head_q] <= 1'b1;
              ftbl_q[head_q] <= tbl_q;
              fpg_q[head_q] <= pg_q;
              pinned_q[head_q] <= 1'b1;
              dirty_q[head_q] <= 1'b0;
              frame_q <= 4'(head_q);
              state_q <= SAge;
            end else if (!vic_q) begin
              status_q <= StAllPinned;
            end else begin
              ev_q <= 1'b1;
              wb_q <= dirty_q[vidx_q];
              evt_q <= ftbl_q[vidx_q];
              evp_q <= fpg_q[vidx_q];
              ftbl_q[vidx_q] <= tbl_q;
              fpg_q[vidx_q] <= pg_q;
              pinned_q[vidx_q] <= 1'b1;
              dirty_q[vidx_q] <= 1'b0;
              frame_q <= 4'(vidx_q);
              old_q <= vrank_q;
              state_q <= SAge;
            end
          end else if (!found_q) begin
            status_q <= StNotResident;
          end else begin
            frame_q <= 4'(fidx_q);
            case (act_q)
              ActUnpin: pinned_q[fidx_q] <= 1'b0;
              ActDirty: dirty_q[fidx_q] <= 1'b1;
              default: begin
                if (pinned_q[fidx_q]) begin
                  pinned_q[fidx_q] <= 1'b0;
                  old_q <= rank_q[fidx_q];
                  state_q <= SAge;
                end
              end
            endcase
          end
        end
        SAge: begin
          if (idx_q == tgt) rank_q[idx_q] <= '0;
          else if (valid_q[idx_q] && (ins_q || rank_q[idx_q] < old_q))
            rank_q[idx_q] <= rank_q[idx_q] + 1'b1;
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            idx_q <= '0;
            state_q <= SOut;
          end
        end
        SOut: begin
          if (!stall_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/lpfm_checker.sv
// port-level checker for the frame manager, bound into the frame manager module
`default_nettype none
`include "assert_macros.svh"
module lpfm_checker
  import lpfm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        stall_o,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [3:0]  frame_o,
  input wire logic        evict_valid_o,
  input wire logic        writeback_o
);
  `ASSERT_ALWAYS(a_status_range, clk_i, rst_ni, !valid_o || status_o == StOk || status_o == StAllPinned || status_o == StNotResident, "bad status")
  `ASSERT_ALWAYS(a_frame_zero, clk_i, rst_ni, !valid_o || status_o == StOk || frame_o == 4'd0, "frame on error")
  `ASSERT_ALWAYS(a_wb_evict, clk_i, rst_ni, !valid_o || !writeback_o || evict_valid_o, "writeback without evict")
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, valid_i && !stall_o, stall_o, "not busy after request")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(frame_o), "result dropped")
endmodule
bind lru_pinned_frame_manager lpfm_checker u_lpfm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .status_o(status_o), .frame_o(frame_o),
  .evict_valid_o(evict_valid_o), .writeback_o(writeback_o)
);
`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench of the lru pinned frame manager
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import lpfm_pkg::*;

  localparam int unsigned NFRAMES = 16;

  typedef struct packed {
    action_e     action;
    logic [15:0] table_id;
    logic [31:0] page_number;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  frame;
    logic        hit;
    logic        evict_valid;
    logic        writeback;
    logic [15:0] evict_table;
    logic [31:0] evict_page;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  action_i = '0;
  logic [15:0] table_id_i = '0;
  logic [31:0] page_number_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  frame_o;
  logic        hit_o;
  logic        evict_valid_o;
  logic        writeback_o;
  logic [15:0] evict_table_o;
  logic [31:0] evict_page_o;

  lru_pinned_frame_manager #(.NUM_FRAMES(NFRAMES)) i_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .action_i, .table_id_i, .page_number_i,
    .valid_o, .stall_i, .status_o, .frame_o, .hit_o, .evict_valid_o, .writeback_o,
    .evict_table_o, .evict_page_o
  );

  always #5 clk_i = ~clk_i;

  // frame manager shadow state
  logic        sh_valid [NFRAMES];
  logic [15:0] sh_table [NFRAMES];
  logic [31:0] sh_page [NFRAMES];
  logic        sh_pinned [NFRAMES];
  logic        sh_dirty [NFRAMES];
  int unsigned sh_rank [NFRAMES];
  int unsigned sh_free [NFRAMES];
  int unsigned sh_free_head;
  int unsigned sh_free_count;

  request_t    pending_requests[$];
  outcome_t    expected_outcomes[$];
  int          errors = 0;
  int unsigned outcomes_seen = 0;
  int unsigned evictions_seen = 0;
  bit          quiet = 1'b0;
  bit          stim_done = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;

  function automatic void make_newest(int f, bit age_all);
    int unsigned old;
    old = sh_rank[f];
    for (int i = 0; i < NFRAMES; i++) begin
      if (i != f && sh_valid[i] && (age_all || sh_rank[i] < old)) sh_rank[i]++;
    end
    sh_rank[f] = 0;
  endfunction

  function automatic outcome_t manage_frame(request_t r);
    outcome_t o;
    int f;
    int victim;
    o = '0;
    o.status = StOk;
    f = -1;
    for (int i = NFRAMES - 1; i >= 0; i--) begin
      if (sh_valid[i] && sh_table[i] == r.table_id && sh_page[i] == r.page_number) f = i;
    end
    if (r.action == ActPin) begin
      if (f >= 0) begin
        o.hit = 1'b1;
        sh_pinned[f] = 1'b1;
        make_newest(f, 1'b0);
        o.frame = f[3:0];
      end else if (sh_free_count > 0) begin
        f = sh_free[sh_free_head];
        sh_free_head = (sh_free_head + 1) % NFRAMES;
        sh_free_count--;
        sh_valid[f] = 1'b1;
        sh_table[f] = r.table_id;
        sh_page[f] = r.page_number;
        sh_pinned[f] = 1'b1;
        sh_dirty[f] = 1'b0;
        make_newest(f, 1'b1);
        o.frame = f[3:0];
      end else begin
        victim = -1;
        for (int i = 0; i < NFRAMES; i++) begin
          if (sh_valid[i] && !sh_pinned[i] && (victim < 0 || sh_rank[i] > sh_rank[victim]))
            victim = i;
        end
        if (victim < 0) begin
          o.status = StAllPinned;
        end else begin
          o.evict_valid = 1'b1;
          o.writeback = sh_dirty[victim];
          o.evict_table = sh_table[victim];
          o.evict_page = sh_page[victim];
          sh_table[victim] = r.table_id;
          sh_page[victim] = r.page_number;
          sh_pinned[victim] = 1'b1;
          sh_dirty[victim] = 1'b0;
          make_newest(victim, 1'b0);
          o.frame = victim[3:0];
        end
      end
    end else if (f < 0) begin
      o.status = StNotResident;
    end else begin
      o.frame = f[3:0];
      case (r.action)
        ActUnpin: sh_pinned[f] = 1'b0;
        ActDirty: sh_dirty[f] = 1'b1;
        default: begin
          if (sh_pinned[f]) begin
            sh_pinned[f] = 1'b0;
            make_newest(f, 1'b0);
          end
        end
      endcase
    end
    return o;
  endfunction

  function automatic request_t req(action_e a, logic [15:0] t, logic [31:0] p);
    request_t r;
    r.action = a;
    r.table_id = t;
    r.page_number = p;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        void'(pending_requests.pop_front());
      end
      if (!(valid_i && stall_o)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 16) - 1;
            valid_i <= 1'b0;
          end else begin
            valid_i <= 1'b1;
            action_i <= pending_requests[0].action;
            table_id_i <= pending_requests[0].table_id;
            page_number_i <= pending_requests[0].page_number;
          end
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // the predictor runs on acceptance, in request order
  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o) begin
      expected_outcomes.push_back(manage_frame(req(action_e'(action_i), table_id_i,
                                                   page_number_i)));
    end
  end

  // monitor
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        got.status = status_e'(status_o);
        got.frame = frame_o;
        got.hit = hit_o;
        got.evict_valid = evict_valid_o;
        got.writeback = writeback_o;
        got.evict_table = evict_table_o;
        got.evict_page = evict_page_o;
        outcomes_seen++;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.evict_valid) evictions_seen++;
          if (got.status != want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          if (got.frame != want.frame)
            $display("%0t: frame expected %0d actual %0d", $time, want.frame, got.frame);
          if (got.hit != want.hit)
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
          if (got.evict_valid != want.evict_valid)
            $display("%0t: evict_valid expected %0d actual %0d", $time, want.evict_valid,
                     got.evict_valid);
          if (got.writeback != want.writeback)
            $display("%0t: writeback expected %0d actual %0d", $time, want.writeback,
                     got.writeback);
          if (got.evict_table != want.evict_table)
            $display("%0t: evict_table expected %h actual %h", $time, want.evict_table,
                     got.evict_table);
          if (got.evict_page != want.evict_page)
            $display("%0t: evict_page expected %h actual %h", $time, want.evict_page,
                     got.evict_page);
          if (got != want) errors++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 16) - 1;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // random request over a small page pool so hits, evictions and pinning all occur
  function automatic request_t random_request();
    logic [15:0] t;
    logic [31:0] p;
    int unsigned a;
    if ($urandom_range(0, 19) == 0) begin
      t = 16'($urandom());
      p = $urandom();
    end else begin
      t = {$urandom_range(0, 1) ? 16'hffff : 16'h0000} ^ 16'($urandom_range(0, 2));
      p = {$urandom_range(0, 1) ? 32'hffffffff : 32'h0} ^ 32'($urandom_range(0, 9));
    end
    a = $urandom_range(0, 9);
    return req(a < 4 ? ActPin : a < 7 ? ActRelease : a < 8 ? ActUnpin : ActDirty, t, p);
  endfunction

  initial begin
    for (int i = 0; i < NFRAMES; i++) begin
      sh_valid[i] = 1'b0;
      sh_table[i] = '0;
      sh_page[i] = '0;
      sh_pinned[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_rank[i] = 0;
      sh_free[i] = i;
    end
    sh_free_head = 0;
    sh_free_count = NFRAMES;

    // directed: not resident, hit, extremes, fill, all pinned, evictions
    pending_requests.push_back(req(ActUnpin, 16'h0, 32'h0));
    pending_requests.push_back(req(ActDirty, 16'hffff, 32'hffffffff));
    pending_requests.push_back(req(ActRelease, 16'h0, 32'h0));
    pending_requests.push_back(req(ActPin, 16'hffff, 32'hffffffff));
    pending_requests.push_back(req(ActPin, 16'hffff, 32'hffffffff));
    pending_requests.push_back(req(ActRelease, 16'hffff, 32'hffffffff));
    pending_requests.push_back(req(ActRelease, 16'hffff, 32'hffffffff));
    pending_requests.push_back(req(ActUnpin, 16'hffff, 32'hffffffff));
    pending_requests.push_back(req(ActDirty, 16'hffff, 32'hffffffff));
    for (int i = 0; i < NFRAMES; i++)
      pending_requests.push_back(req(ActPin, 16'h0, 32'(i)));
    pending_requests.push_back(req(ActPin, 16'h1, 32'h0));
    pending_requests.push_back(req(ActPin, 16'h1, 32'h1));
    for (int i = 0; i < NFRAMES; i++)
      pending_requests.push_back(req(i % 2 ? ActUnpin : ActRelease, 16'h0, 32'(i)));
    pending_requests.push_back(req(ActDirty, 16'h0, 32'h3));
    for (int i = 0; i < 6; i++)
      pending_requests.push_back(req(ActPin, 16'h2, 32'(i)));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 1750; i++) begin
      if (i == 1500) quiet = 1'b1;
      pending_requests.push_back(random_request());
      while (pending_requests.size() > 4) @(posedge clk_i);
    end
    while (pending_requests.size() > 0 || expected_outcomes.size() > 0) @(posedge clk_i);
    repeat (3 * NFRAMES + 10) @(posedge clk_i);
    $display("checked %0d frame requests, %0d with eviction", outcomes_seen, evictions_seen);
    if (errors == 0) begin
      $display("PASS lru_pinned_frame_manager");
    end else begin
      $display("FAIL lru_pinned_frame_manager");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL lru_pinned_frame_manager");
    $finish;
  end
endmodule
`default_nettype wire

>>> lru_pinned_frame_manager.f
+incdir+hw/rtl
hw/rtl/lpfm_pkg.sv
hw/rtl/lru_pinned_frame_manager.sv
hw/rtl/lpfm_checker.sv
test/tb_top.sv
